[hw/rtl/itp_pkg.sv]
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, types and helper functions of the infix to postfix core.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_MUL   = 8'h2A;
    localparam logic [7:0] CHAR_DIV   = 8'h2F;

    // stack entry code; bit 1 marks the high precedence class
    typedef logic [1:0] t_op_code;

    localparam t_op_code OP_PLUS  = 2'd0;
    localparam t_op_code OP_MINUS = 2'd1;
    localparam t_op_code OP_MUL   = 2'd2;
    localparam t_op_code OP_DIV   = 2'd3;

    // one result beat handed from the sequencer to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] symbol;
        logic       last;
        logic       flag;
    } t_emit;

    function automatic logic is_op(input logic [7:0] sym);
        return (sym == CHAR_PLUS) || (sym == CHAR_MINUS) ||
               (sym == CHAR_MUL) || (sym == CHAR_DIV);
    endfunction

    function automatic t_op_code op_code(input logic [7:0] sym);
        t_op_code code;
        case (sym)
            CHAR_MINUS: code = OP_MINUS;
            CHAR_MUL:   code = OP_MUL;
            CHAR_DIV:   code = OP_DIV;
            default:    code = OP_PLUS;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] op_char(input t_op_code code);
        logic [7:0] ch;
        case (code)
            OP_PLUS:  ch = CHAR_PLUS;
            OP_MINUS: ch = CHAR_MINUS;
            OP_MUL:   ch = CHAR_MUL;
            OP_DIV:   ch = CHAR_DIV;
            default:  ch = CHAR_PLUS;
        endcase
        return ch;
    endfunction

    // stacked entry has equal or higher precedence than the incoming operator
    function automatic logic prec_ge(input t_op_code stacked, input t_op_code incoming);
        return stacked[1] | ~incoming[1];
    endfunction

endpackage

[hw/rtl/infix_to_postfix_converter_core.sv]
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard conversion of a + - * / character stream to postfix order.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata            tlast        tuser
// s_axis    in   [7:0] symbol     end_of_expr  -
// m_axis    out  [7:0] out_symbol run_last     [0] overflow_seen
//
// A character is taken in S_IDLE and handled in S_WORK. An operator pops
// one stacked entry at a time and a flush pops each stacked entry; the
// stack memory read port delivers one top entry per cycle while the
// output register is free, which sets the pop rate.
// Reset is synchronous and active low; it empties the stack at once.
// A stalled output beat holds in the output register and freezes pops.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] symbol
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_symbol
    output logic       o_m_axis_tlast,
    output logic [0:0] o_m_axis_tuser    // [0] overflow_seen
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    itp_pkg::t_emit    emit;
    logic              out_free;
    logic              we;
    logic [AW-1:0]     waddr;
    itp_pkg::t_op_code wdata;
    logic [CW-1:0]     cnt_next;
    itp_pkg::t_op_code top;
    itp_pkg::t_op_code sec;

    logic       r_ovalid;
    logic [7:0] r_osym;
    logic       r_olast;
    logic       r_oflag;

    assign out_free = !r_ovalid || i_m_axis_tready;

    itp_ctrl #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_symbol  (i_s_axis_tdata),
        .i_end     (i_s_axis_tlast),
        .i_out_free(out_free),
        .o_emit    (emit),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_cnt_next(cnt_next),
        .i_top     (top),
        .i_sec     (sec)
    );

    itp_stack_mem #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_cnt_next(cnt_next),
        .o_top     (top),
        .o_sec     (sec)
    );

    // output register: load a new beat whenever the slot is empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= emit.valid;
        end
        if (out_free && emit.valid) begin
            r_osym  <= emit.symbol;
            r_olast <= emit.last;
            r_oflag <= emit.flag;
        end
    end

    assign o_m_axis_tvalid   = r_ovalid;
    assign o_m_axis_tdata    = r_osym;
    assign o_m_axis_tlast    = r_olast;
    assign o_m_axis_tuser[0] = r_oflag;

endmodule

[hw/rtl/itp_stack_mem.sv]
// ----------------------------------------------------------------------------
// itp_stack_mem
// Operator stack storage: one write port, two registered read ports that
// track the top and the entry below it for the next stack count.
// ----------------------------------------------------------------------------
module itp_stack_mem #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(STACK_DEPTH)-1:0]   i_waddr,
    input  itp_pkg::t_op_code                i_wdata,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] i_cnt_next,
    output itp_pkg::t_op_code                o_top,
    output itp_pkg::t_op_code                o_sec
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    itp_pkg::t_op_code r_mem [STACK_DEPTH];
    itp_pkg::t_op_code r_top;
    itp_pkg::t_op_code r_sec;

    logic [CW-1:0] top_idx;
    logic [CW-1:0] sec_idx;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] sec_addr;

    always_comb begin
        top_idx  = (i_cnt_next >= CW'(1)) ? (i_cnt_next - CW'(1)) : '0;
        sec_idx  = (i_cnt_next >= CW'(2)) ? (i_cnt_next - CW'(2)) : '0;
        top_addr = top_idx[AW-1:0];
        sec_addr = sec_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // forward a same-cycle push into the read data
        r_top <= (i_we && (i_waddr == top_addr)) ? i_wdata : r_mem[top_addr];
        r_sec <= (i_we && (i_waddr == sec_addr)) ? i_wdata : r_mem[sec_addr];
    end

    assign o_top = r_top;
    assign o_sec = r_sec;

endmodule

[hw/rtl/itp_ctrl.sv]
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer: takes one character, emits an operand, pops by precedence,
// pushes or drops the operator, and flushes the stack at expression end.
// ----------------------------------------------------------------------------
module itp_ctrl #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_symbol,
    input  logic                             i_end,
    input  logic                             i_out_free,
    output itp_pkg::t_emit                   o_emit,
    output logic                             o_we,
    output logic [$clog2(STACK_DEPTH)-1:0]   o_waddr,
    output itp_pkg::t_op_code                o_wdata,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_cnt_next,
    input  itp_pkg::t_op_code                i_top,
    input  itp_pkg::t_op_code                i_sec
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_FLUSH
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_sticky, n_sticky;
    logic [7:0]    r_sym, n_sym;
    logic          r_end, n_end;

    logic              sym_is_op;
    itp_pkg::t_op_code sym_code;
    logic              can_pop;

    always_comb begin
        sym_is_op = itp_pkg::is_op(r_sym);
        sym_code  = itp_pkg::op_code(r_sym);
        can_pop   = (r_count != '0) && itp_pkg::prec_ge(i_top, sym_code);

        n_state  = r_state;
        n_count  = r_count;
        n_sticky = r_sticky;
        n_sym    = r_sym;
        n_end    = r_end;
        o_emit   = '0;
        o_we     = 1'b0;
        o_waddr  = r_count[AW-1:0];
        o_wdata  = sym_code;
        o_ready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sym   = i_symbol;
                    n_end   = i_end;
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (!sym_is_op) begin
                    if (i_out_free) begin
                        o_emit.valid  = 1'b1;
                        o_emit.symbol = r_sym;
                        o_emit.last   = !r_end || (r_count == '0);
                        o_emit.flag   = r_sticky;
                        if (r_end && (r_count != '0)) begin
                            n_state = S_FLUSH;
                        end else begin
                            if (r_end) begin
                                n_sticky = 1'b0;
                            end
                            n_state = S_IDLE;
                        end
                    end
                end else if (can_pop) begin
                    // pop one beat; last only if the next entry stops the run
                    if (i_out_free) begin
                        o_emit.valid  = 1'b1;
                        o_emit.symbol = itp_pkg::op_char(i_top);
                        o_emit.last   = !r_end && ((r_count == CW'(1)) ||
                                        !itp_pkg::prec_ge(i_sec, sym_code));
                        o_emit.flag   = r_sticky;
                        n_count       = r_count - CW'(1);
                    end
                end else begin
                    if (r_count == CW'(STACK_DEPTH)) begin
                        n_sticky = 1'b1;
                    end else begin
                        o_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                    n_state = r_end ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_out_free) begin
                    o_emit.valid  = 1'b1;
                    o_emit.symbol = itp_pkg::op_char(i_top);
                    o_emit.last   = (r_count == CW'(1));
                    o_emit.flag   = r_sticky;
                    n_count       = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_sticky = 1'b0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_cnt_next = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sticky <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sticky <= n_sticky;
        end
        r_sym <= n_sym;
        r_end <= n_end;
    end

endmodule
